@@ hw/rtl/wsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared widths, defaults and register indexes of the world-to-screen
// projection core.
// ----------------------------------------------------------------------------
package wsp_pkg;

  // Field and register widths
  localparam int DATA_W      = 32;
  localparam int COEF_W      = 64;
  localparam int VIEW_W      = 14;
  localparam int REG_IDX_W   = 4;

  // Default fractional bits of the fixed-point format
  localparam int FRAC_BITS_DEF = 16;

  // Quotient bits produced by the divider (cap sits at 2^QUOT_BITS)
  localparam int QUOT_BITS = 40;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_COEF_X_LO = 4'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_X_HI = 4'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEF_Y_LO = 4'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEF_Y_HI = 4'd3;
  localparam logic [REG_IDX_W-1:0] REG_COEF_W_LO = 4'd4;
  localparam logic [REG_IDX_W-1:0] REG_COEF_W_HI = 4'd5;
  localparam logic [REG_IDX_W-1:0] REG_VIEW_W    = 4'd6;
  localparam logic [REG_IDX_W-1:0] REG_VIEW_H    = 4'd7;

endpackage

@@ hw/rtl/world_to_screen_projection_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_screen_projection_core
// Projects a world point through the x, y and w rows of a 4x4 matrix,
// divides by w and maps the result to viewport pixel coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries world_x, world_y, world_z.
//   Output channel (out_valid / out_stall) carries visible, screen_x,
//   screen_y. A transaction completes when valid is high and stall is low.
//   The configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data)
//   writes the matrix rows and viewport size; cfg_ready is always high and
//   writes to unknown indexes are dropped. Write only while the core is idle.
// Pipeline and throughput:
//   There are 45 register stages, the first loaded by the accepting edge:
//   one product stage, one clip-sum stage, a divider set-up stage, forty
//   one-bit restoring divider stages (the bulk of the depth), a scaling
//   multiplier and an output stage. One point is taken every cycle while
//   in_stall is low.
// Reset:
//   rst zeroes the config registers and valid bits, emptying the pipeline.
// Stall:
//   Each stage advances when it is empty or the next one advances, so a
//   stalled output still lets bubbles fill up; in_stall rises only once every
//   stage holds a point.
// ----------------------------------------------------------------------------
module world_to_screen_projection_core #(
  parameter int FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // configuration
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [wsp_pkg::REG_IDX_W-1:0]           cfg_index,
  input  logic [wsp_pkg::COEF_W-1:0]              cfg_data,
  // input points
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [wsp_pkg::DATA_W-1:0]       world_x,
  input  logic signed [wsp_pkg::DATA_W-1:0]       world_y,
  input  logic signed [wsp_pkg::DATA_W-1:0]       world_z,
  // results
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    visible,
  output logic signed [wsp_pkg::DATA_W-1:0]       screen_x,
  output logic signed [wsp_pkg::DATA_W-1:0]       screen_y
);

  localparam int DW   = wsp_pkg::DATA_W;
  localparam int PRW  = 2 * DW;                 // product width
  localparam int TW   = PRW - FRAC_BITS;        // floored product width
  localparam int CW   = TW + 2;                 // clip sum width
  localparam int QB   = wsp_pkg::QUOT_BITS;
  localparam int VW   = wsp_pkg::VIEW_W;
  localparam int NW   = QB + 2;                 // signed ndc width
  localparam int PW   = VW + NW;                // scaled ndc width
  localparam int SW   = PW + 1;                 // screen sum width
  localparam int W_MIN = ((1 << FRAC_BITS) + 5) / 10;

  typedef struct packed {
    logic [CW-2:0] d;
    logic [CW-1:0] rx;
    logic [CW-1:0] ry;
    logic [QB-1:0] nx;
    logic [QB-1:0] ny;
    logic [QB-1:0] qx;
    logic [QB-1:0] qy;
    logic          negx;
    logic          negy;
    logic          ovx;
    logic          ovy;
    logic          vis;
  } div_stage_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [wsp_pkg::COEF_W-1:0] coef_x_lo, coef_x_hi, coef_y_lo, coef_y_hi;
  logic [wsp_pkg::COEF_W-1:0] coef_w_lo, coef_w_hi;
  logic [VW-1:0]              view_width, view_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_x_lo   <= '0;
      coef_x_hi   <= '0;
      coef_y_lo   <= '0;
      coef_y_hi   <= '0;
      coef_w_lo   <= '0;
      coef_w_hi   <= '0;
      view_width  <= '0;
      view_height <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wsp_pkg::REG_COEF_X_LO: coef_x_lo   <= cfg_data;
        wsp_pkg::REG_COEF_X_HI: coef_x_hi   <= cfg_data;
        wsp_pkg::REG_COEF_Y_LO: coef_y_lo   <= cfg_data;
        wsp_pkg::REG_COEF_Y_HI: coef_y_hi   <= cfg_data;
        wsp_pkg::REG_COEF_W_LO: coef_w_lo   <= cfg_data;
        wsp_pkg::REG_COEF_W_HI: coef_w_hi   <= cfg_data;
        wsp_pkg::REG_VIEW_W:    view_width  <= cfg_data[VW-1:0];
        wsp_pkg::REG_VIEW_H:    view_height <= cfg_data[VW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage advance chain: a stage moves when empty or when its successor moves
  // --------------------------------------------------------------------------
  logic          en_p, en_c, en_m, en_o;
  logic [QB:0]   en_d;
  logic          v_p, v_c, v_m;
  logic [QB:0]   v_d;

  assign en_o = !out_valid || !out_stall;
  assign en_m = !v_m || en_o;
  assign en_d[QB] = !v_d[QB] || en_m;
  for (genvar k = 0; k < QB; k++) begin : g_en
    assign en_d[k] = !v_d[k] || en_d[k+1];
  end
  assign en_c = !v_c || en_d[0];
  assign en_p = !v_p || en_c;
  assign in_stall = !en_p;

  // --------------------------------------------------------------------------
  // Stage P: the nine 32x32 products
  // --------------------------------------------------------------------------
  logic signed [PRW-1:0] px0, px1, px2, py0, py1, py2, pw0, pw1, pw2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p <= 1'b0;
    end else if (en_p) begin
      v_p <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_p) begin
      px0 <= world_x * $signed(coef_x_lo[DW-1:0]);
      px1 <= world_y * $signed(coef_x_lo[PRW-1:DW]);
      px2 <= world_z * $signed(coef_x_hi[DW-1:0]);
      py0 <= world_x * $signed(coef_y_lo[DW-1:0]);
      py1 <= world_y * $signed(coef_y_lo[PRW-1:DW]);
      py2 <= world_z * $signed(coef_y_hi[DW-1:0]);
      pw0 <= world_x * $signed(coef_w_lo[DW-1:0]);
      pw1 <= world_y * $signed(coef_w_lo[PRW-1:DW]);
      pw2 <= world_z * $signed(coef_w_hi[DW-1:0]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: floored products summed with the translation term
  // --------------------------------------------------------------------------
  function automatic logic signed [CW-1:0] row_sum(
    input logic signed [PRW-1:0] a,
    input logic signed [PRW-1:0] b,
    input logic signed [PRW-1:0] c,
    input logic signed [DW-1:0]  t
  );
    logic signed [PRW-1:0] fa, fb, fc;
    begin
      fa = a >>> FRAC_BITS;
      fb = b >>> FRAC_BITS;
      fc = c >>> FRAC_BITS;
      row_sum = CW'(fa[TW-1:0]) - CW'(0)
              + $signed({{2{fb[TW-1]}}, fb[TW-1:0]})
              + $signed({{2{fc[TW-1]}}, fc[TW-1:0]})
              + $signed({{(CW-DW){t[DW-1]}}, t});
      row_sum = row_sum - CW'(fa[TW-1:0])
              + $signed({{2{fa[TW-1]}}, fa[TW-1:0]});
    end
  endfunction

  logic signed [CW-1:0] cx, cy, cw;
  logic                 vis_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c <= 1'b0;
    end else if (en_c) begin
      v_c <= v_p;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      cx <= row_sum(px0, px1, px2, $signed(coef_x_hi[PRW-1:DW]));
      cy <= row_sum(py0, py1, py2, $signed(coef_y_hi[PRW-1:DW]));
      cw <= row_sum(pw0, pw1, pw2, $signed(coef_w_hi[PRW-1:DW]));
    end
  end

  assign vis_c = (cw >= $signed(CW'(W_MIN)));

  // --------------------------------------------------------------------------
  // Stage D0: magnitudes, overflow (cap) check and divider set-up
  // --------------------------------------------------------------------------
  div_stage_t           dstg [QB+1];
  logic [CW-1:0]        ax, ay;
  logic [CW+FRAC_BITS-1:0] shx, shy;
  logic [CW-1:0]        r0x, r0y;
  div_stage_t           d0_next;

  always_comb begin
    ax  = cx[CW-1] ? CW'(-cx) : CW'(cx);
    ay  = cy[CW-1] ? CW'(-cy) : CW'(cy);
    shx = {ax, {FRAC_BITS{1'b0}}};
    shy = {ay, {FRAC_BITS{1'b0}}};
    r0x = {{(QB-FRAC_BITS){1'b0}}, shx[CW+FRAC_BITS-1:QB]};
    r0y = {{(QB-FRAC_BITS){1'b0}}, shy[CW+FRAC_BITS-1:QB]};
    d0_next.d    = cw[CW-2:0];
    d0_next.rx   = r0x;
    d0_next.ry   = r0y;
    d0_next.nx   = shx[QB-1:0];
    d0_next.ny   = shy[QB-1:0];
    d0_next.qx   = '0;
    d0_next.qy   = '0;
    d0_next.negx = cx[CW-1];
    d0_next.negy = cy[CW-1];
    d0_next.ovx  = (r0x >= {1'b0, cw[CW-2:0]});
    d0_next.ovy  = (r0y >= {1'b0, cw[CW-2:0]});
    d0_next.vis  = vis_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_d[0] <= 1'b0;
    end else if (en_d[0]) begin
      v_d[0] <= v_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d[0]) begin
      dstg[0] <= d0_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stages D1..D40: one restoring quotient bit per stage for x and y
  // --------------------------------------------------------------------------
  for (genvar k = 1; k <= QB; k++) begin : g_div
    logic [CW-1:0] r2x, r2y;
    logic          gex, gey;
    div_stage_t    dn;

    always_comb begin
      r2x = {dstg[k-1].rx[CW-2:0], dstg[k-1].nx[QB-1]};
      r2y = {dstg[k-1].ry[CW-2:0], dstg[k-1].ny[QB-1]};
      gex = (r2x >= {1'b0, dstg[k-1].d});
      gey = (r2y >= {1'b0, dstg[k-1].d});
      dn    = dstg[k-1];
      dn.rx = gex ? (r2x - {1'b0, dstg[k-1].d}) : r2x;
      dn.ry = gey ? (r2y - {1'b0, dstg[k-1].d}) : r2y;
      dn.nx = {dstg[k-1].nx[QB-2:0], 1'b0};
      dn.ny = {dstg[k-1].ny[QB-2:0], 1'b0};
      dn.qx = {dstg[k-1].qx[QB-2:0], gex};
      dn.qy = {dstg[k-1].qy[QB-2:0], gey};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_d[k] <= 1'b0;
      end else if (en_d[k]) begin
        v_d[k] <= v_d[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en_d[k]) begin
        dstg[k] <= dn;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage M: cap, sign and scale by the half sizes
  // --------------------------------------------------------------------------
  logic [QB:0]          qmx, qmy;
  logic signed [NW-1:0] ndx, ndy;
  logic signed [VW-1:0] hw_s, hh_s;
  logic signed [PW-1:0] sclx, scly;
  logic                 vis_m;

  always_comb begin
    qmx  = dstg[QB].ovx ? {1'b1, {QB{1'b0}}} : {1'b0, dstg[QB].qx};
    qmy  = dstg[QB].ovy ? {1'b1, {QB{1'b0}}} : {1'b0, dstg[QB].qy};
    ndx  = dstg[QB].negx ? -$signed({1'b0, qmx}) : $signed({1'b0, qmx});
    ndy  = dstg[QB].negy ? -$signed({1'b0, qmy}) : $signed({1'b0, qmy});
    hw_s = $signed({1'b0, view_width[VW-1:1]});
    hh_s = $signed({1'b0, view_height[VW-1:1]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_m <= 1'b0;
    end else if (en_m) begin
      v_m <= v_d[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en_m) begin
      sclx  <= hw_s * ndx;
      scly  <= hh_s * ndy;
      vis_m <= dstg[QB].vis;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: add viewport offset, saturate, zero when not visible
  // --------------------------------------------------------------------------
  localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] SAT_MIN = -SW'(64'sd2147483648);

  logic signed [SW-1:0] offx, offy, sumx, sumy;
  logic signed [DW-1:0] satx, saty;

  always_comb begin
    offx = $signed(SW'({1'b0, view_width[VW-1:1]}) << FRAC_BITS);
    offy = $signed(SW'({1'b0, view_height[VW-1:1]}) << FRAC_BITS);
    sumx = offx + $signed({sclx[PW-1], sclx});
    sumy = offy - $signed({scly[PW-1], scly});
    if (sumx > SAT_MAX) begin
      satx = SAT_MAX[DW-1:0];
    end else if (sumx < SAT_MIN) begin
      satx = SAT_MIN[DW-1:0];
    end else begin
      satx = sumx[DW-1:0];
    end
    if (sumy > SAT_MAX) begin
      saty = SAT_MAX[DW-1:0];
    end else if (sumy < SAT_MIN) begin
      saty = SAT_MIN[DW-1:0];
    end else begin
      saty = sumy[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_o) begin
      out_valid <= v_m;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      visible  <= vis_m;
      screen_x <= vis_m ? satx : '0;
      screen_y <= vis_m ? saty : '0;
    end
  end

endmodule

@@ bench/tb_world_to_screen_projection_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_world_to_screen_projection_core
// Self-checking bench for the world-to-screen projection core. A scoreboard
// class predicts each point's visibility and screen position from its own
// copy of the matrix and viewport registers. Directed points cover the
// field extremes, the near-eye cut, zero viewports, saturation and dropped
// register writes. Random phases follow, each under new register values,
// with random gaps on both channels, one long output hold-off and one
// mid-phase wait until every outstanding result is back.
// ----------------------------------------------------------------------------

class proj_scoreboard;
  typedef struct {
    bit          vis;
    logic [31:0] sx;
    logic [31:0] sy;
  } point_res_t;

  localparam int  FB    = wsp_pkg::FRAC_BITS_DEF;
  localparam longint W_MIN = ((longint'(1) << FB) + 5) / 10;

  logic [63:0]  regs [8];
  point_res_t   expected_q [$];
  int           errors;

  function new();
    foreach (regs[i]) regs[i] = '0;
    errors = 0;
  endfunction

  function void write_reg(logic [3:0] idx, logic [63:0] data);
    if (idx > wsp_pkg::REG_VIEW_H) return;
    if (idx >= wsp_pkg::REG_VIEW_W) data = data & 64'h3FFF;
    regs[idx] = data;
  endfunction

  // One clip row: floored products plus the translation term
  function longint clip_row(logic [63:0] lo, logic [63:0] hi,
                            longint x, longint y, longint z);
    longint m0, m1, m2, m3;
    m0 = longint'($signed(lo[31:0]));
    m1 = longint'($signed(lo[63:32]));
    m2 = longint'($signed(hi[31:0]));
    m3 = longint'($signed(hi[63:32]));
    return ((x * m0) >>> FB) + ((y * m1) >>> FB) + ((z * m2) >>> FB) + m3;
  endfunction

  // Fixed-point quotient truncated toward zero, magnitude capped at 2^40
  function longint ndc_ratio(longint num, longint den);
    logic [127:0] a, d, q;
    bit neg;
    neg = num < 0;
    a = 128'(neg ? -num : num);
    d = 128'(den);
    if (a / d >= (128'(1) << (wsp_pkg::QUOT_BITS - FB))) q = 128'(1) << wsp_pkg::QUOT_BITS;
    else q = (a << FB) / d;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function void note_point(logic [31:0] wx, logic [31:0] wy, logic [31:0] wz);
    longint x, y, z, cw, cx, cy, hw, hh;
    point_res_t r;
    x = longint'($signed(wx));
    y = longint'($signed(wy));
    z = longint'($signed(wz));
    cw = clip_row(regs[4], regs[5], x, y, z);
    if (cw < W_MIN) begin
      r.vis = 0; r.sx = '0; r.sy = '0;
    end else begin
      cx = clip_row(regs[0], regs[1], x, y, z);
      cy = clip_row(regs[2], regs[3], x, y, z);
      hw = longint'(regs[6][13:1]);
      hh = longint'(regs[7][13:1]);
      r.vis = 1;
      r.sx = sat32(hw * ndc_ratio(cx, cw) + (hw << FB));
      r.sy = sat32(-(hh * ndc_ratio(cy, cw)) + (hh << FB));
    end
    expected_q.push_back(r);
  endfunction

  function void check_result(bit vis, logic [31:0] sx, logic [31:0] sy);
    point_res_t e;
    if (expected_q.size() == 0) begin
      $error("result with no transaction outstanding: visible=%0d x=%h y=%h", vis, sx, sy);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (vis !== e.vis) begin
      $error("visible: expected %0d, got %0d", e.vis, vis); errors++;
    end
    if (sx !== e.sx) begin
      $error("screen_x: expected %h, got %h", e.sx, sx); errors++;
    end
    if (sy !== e.sy) begin
      $error("screen_y: expected %h, got %h", e.sy, sy); errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_world_to_screen_projection_core;

  localparam int CYCLE_LIMIT = 400000;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [3:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;
  logic               in_valid = 0;
  logic               in_stall;
  logic signed [31:0] world_x = '0, world_y = '0, world_z = '0;
  logic               out_valid;
  logic               out_stall = 0;
  logic               visible;
  logic signed [31:0] screen_x, screen_y;

  proj_scoreboard sb = new();
  int  sent = 0;
  int  hold_req = 0;
  int  cycles = 0;

  world_to_screen_projection_core DUT (.*);

  always #2 clk = ~clk;

  // Gap rates: sender 33 / receiver 54, then swapped, then none
  function int snd_pct();
    return sent < 550 ? 33 : (sent < 1100 ? 54 : 0);
  endfunction
  function int rcv_pct();
    return sent < 550 ? 54 : (sent < 1100 ? 33 : 0);
  endfunction

  // Receiver: random stalls plus a counted long hold-off on request
  always @(negedge clk) begin
    static int hold_left = 0;
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_pct());
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(visible, screen_x, screen_y);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic cfg_write(logic [3:0] idx, logic [63:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < snd_pct()) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    world_x  <= x;
    world_y  <= y;
    world_z  <= z;
    do @(posedge clk); while (in_stall);
    sb.note_point(x, y, z);
    sent++;
    @(negedge clk);
  endtask

  // Wait for the pipeline to empty, then allow for its depth
  task automatic drain();
    in_valid <= 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic [31:0] small_word(int span);
    return 32'($signed($urandom_range(2 * span)) - span);
  endfunction

  function automatic logic [31:0] coord();
    if ($urandom_range(99) < 15) return $urandom;
    return small_word(1 << 20);
  endfunction

  // Plausible perspective matrix with mostly positive clip w
  task automatic rand_matrix();
    cfg_write(wsp_pkg::REG_COEF_X_LO, {small_word(1 << 17), small_word(1 << 17)});
    cfg_write(wsp_pkg::REG_COEF_X_HI, {small_word(1 << 20), small_word(1 << 17)});
    cfg_write(wsp_pkg::REG_COEF_Y_LO, {small_word(1 << 17), small_word(1 << 17)});
    cfg_write(wsp_pkg::REG_COEF_Y_HI, {small_word(1 << 20), small_word(1 << 17)});
    cfg_write(wsp_pkg::REG_COEF_W_LO, {small_word(1 << 14), small_word(1 << 14)});
    cfg_write(wsp_pkg::REG_COEF_W_HI,
              {32'($urandom_range(64) << 16), small_word(1 << 14)});
  endtask

  initial begin
    logic [63:0] v;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: all registers at reset, so every point is behind the eye
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_point(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF);
    drain();

    // Identity-like projection with w fixed at one
    cfg_write(wsp_pkg::REG_COEF_X_LO, {32'h0, 32'h0001_0000});
    cfg_write(wsp_pkg::REG_COEF_X_HI, 64'h0);
    cfg_write(wsp_pkg::REG_COEF_Y_LO, {32'h0001_0000, 32'h0});
    cfg_write(wsp_pkg::REG_COEF_Y_HI, 64'h0);
    cfg_write(wsp_pkg::REG_COEF_W_LO, 64'h0);
    cfg_write(wsp_pkg::REG_COEF_W_HI, {32'h0001_0000, 32'h0});
    cfg_write(wsp_pkg::REG_VIEW_W, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(wsp_pkg::REG_VIEW_H, 64'd1080);
    // Dropped writes beyond the register list
    cfg_write(4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(4'd15, 64'h1234_5678_9ABC_DEF0);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0);
    send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    drain();

    // Near-eye cut on both sides of 0.1, tiny w for saturation
    cfg_write(wsp_pkg::REG_COEF_W_HI, {32'd6553, 32'h0});
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0);
    drain();
    cfg_write(wsp_pkg::REG_COEF_W_HI, {32'd6554, 32'h0});
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    drain();
    cfg_write(wsp_pkg::REG_COEF_W_HI, {32'hFFFF_0000, 32'h0});
    send_point(32'h0001_0000, 32'h0, 32'h0);
    drain();

    // Viewport of width 0 and height 1, so both half sizes are zero
    cfg_write(wsp_pkg::REG_COEF_W_HI, {32'h0001_0000, 32'h0});
    cfg_write(wsp_pkg::REG_VIEW_W, 64'h0);
    cfg_write(wsp_pkg::REG_VIEW_H, 64'h1);
    send_point(32'h0003_0000, 32'hFFFD_0000, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
    drain();

    // Random phases, each under fresh register values
    for (int p = 0; p < 6; p++) begin
      if (p == 5) begin
        // Unconstrained words on every register
        for (int r = 0; r < 6; r++) cfg_write(4'(r), {$urandom, $urandom});
      end else begin
        rand_matrix();
      end
      case (p)
        1:       v = 64'd16383;
        2:       v = 64'd0;
        default: v = {$urandom, $urandom};
      endcase
      cfg_write(wsp_pkg::REG_VIEW_W, v);
      cfg_write(wsp_pkg::REG_VIEW_H, p == 2 ? 64'd16383 : {$urandom, $urandom});
      if (p == 1) hold_req = 300;
      for (int i = 0; i < 275; i++) begin
        if (p == 3 && i == 140) begin
          // Sender waits for every outstanding result
          in_valid <= 0;
          while (sb.pending() != 0) @(negedge clk);
        end
        send_point(coord(), coord(), coord());
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/wsp_pkg.sv
hw/rtl/world_to_screen_projection_core.sv
bench/tb_world_to_screen_projection_core.sv
